### rtl/bmlp_pkg.sv
package bmlp_pkg;

   localparam int HIDDEN_COUNT = 120;
   localparam int ROW_COUNT    = HIDDEN_COUNT + 1;
   localparam int HIGH_BITS    = 64;
   localparam int LOW_BITS     = 56;
   localparam int ROW_BITS     = HIGH_BITS + LOW_BITS;
   localparam int ADDR_W       = $clog2(ROW_COUNT);
   localparam int THR_W        = 7;
   localparam int SCORE_W      = 7;
   localparam int POP_W        = 128;
   localparam int POP_LEVELS   = 7;

   localparam logic [ADDR_W-1:0] OUT_ROW   = ADDR_W'(HIDDEN_COUNT);
   localparam logic [THR_W-1:0]  THR_RESET = THR_W'(60);

   // csr register indexes
   localparam logic REG_FIRE_THRESHOLD = 1'b0;

   typedef enum logic {
      OP_WRITE    = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   // lane masks of the popcount tree, one per level
   localparam logic [POP_W-1:0] POP_MASK [POP_LEVELS] = '{
      {2{64'h5555_5555_5555_5555}},
      {2{64'h3333_3333_3333_3333}},
      {2{64'h0f0f_0f0f_0f0f_0f0f}},
      {2{64'h00ff_00ff_00ff_00ff}},
      {2{64'h0000_ffff_0000_ffff}},
      {2{64'h0000_0000_ffff_ffff}},
      {64'h0, 64'hffff_ffff_ffff_ffff}
   };

   typedef struct packed {
      logic [SCORE_W-1:0] count;
      logic               fire;
   } agree_result_type;

endpackage

### rtl/binarized_mlp_classifier_core.sv
// a classify word is accepted only while idle; the next word waits until
//    its result is registered. A single xnor-popcount unit scores one
//    weight row per cycle over 121 rows, then holds the output row in drain
// a weight write word is accepted only while idle and leaves the core idle
// reset (synchronous): all weight rows read as zero, threshold returns to 60
module binarized_mlp_classifier_core
   import bmlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // row_index, weight_high, weight_low, feature_high, feature_low, one zero pad bit
   input  logic [247:0] req_tdata,
   // op
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // class_bit, output_score
   output logic [7:0]   rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic [ADDR_W-1:0]    s1_row_ff, s1_row_in;
   logic                 rd_ok_ff, rd_ok_in;
   logic [ROW_COUNT-1:0] valid_ff, valid_in;
   logic [ROW_BITS-1:0]  feature_ff, feature_in;
   logic [ROW_BITS-1:0]  hid_ff, hid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]   score_ff, score_in;
   logic                 class_ff, class_in;

   logic [THR_W-1:0]     threshold;
   logic                 accept;
   op_type               op;
   logic [ADDR_W-1:0]    row_index;
   logic [ROW_BITS-1:0]  weight_row;
   logic [ROW_BITS-1:0]  feature_row;
   logic                 wr_en;
   logic                 rd_en;
   logic [ROW_BITS-1:0]  rd_data;
   logic [ROW_BITS-1:0]  operand;
   logic [ROW_BITS-1:0]  weight;
   logic [ROW_BITS-1:0]  hidden;
   logic                 out_free;
   agree_result_type     agree;

   assign op          = op_type'(req_tuser);
   assign row_index   = req_tdata[6:0];
   assign weight_row  = {req_tdata[70:7], req_tdata[126:71]};
   assign feature_row = {req_tdata[190:127], req_tdata[246:191]};

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign wr_en      = accept && (op == OP_WRITE) && (row_index < OUT_ROW + 1'b1);
   assign rd_en      = (state_ff == ST_RUN);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bmlp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .threshold (threshold)
   );

   bmlp_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROW_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (row_index),
      .wr_data (weight_row),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // shift order puts neuron 0 on top; swap halves into {high word, low word}
   assign hidden  = {hid_ff[HIGH_BITS-1:0], hid_ff[ROW_BITS-1:HIGH_BITS]};
   assign operand = (s1_row_ff == OUT_ROW) ? hidden : feature_ff;
   // a row never written scores against zero
   assign weight  = rd_ok_ff ? rd_data : '0;

   bmlp_agree u_agree (
      .operand   (operand),
      .weight    (weight),
      .threshold (threshold),
      .result    (agree)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      s1_vld_in    = s1_vld_ff;
      s1_row_in    = s1_row_ff;
      rd_ok_in     = rd_ok_ff;
      valid_in     = valid_ff;
      feature_in   = feature_ff;
      hid_in       = hid_ff;
      rsp_valid_in = rsp_valid_ff;
      score_in     = score_ff;
      class_in     = class_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_en) begin
         valid_in[row_index] = 1'b1;
      end

      if (s1_vld_ff && (s1_row_ff != OUT_ROW)) begin
         hid_in = {hid_ff[ROW_BITS-2:0], agree.fire};
      end

      unique case (state_ff)
         ST_IDLE: begin
            s1_vld_in = 1'b0;
            if (accept && (op == OP_CLASSIFY)) begin
               feature_in = feature_row;
               addr_in    = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            s1_vld_in = 1'b1;
            s1_row_in = addr_ff;
            rd_ok_in  = valid_ff[addr_ff];
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == OUT_ROW) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // output row sits in stage one until the result register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               score_in     = agree.count;
               class_in     = agree.fire;
               s1_vld_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_vld_ff    <= s1_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      s1_row_ff  <= s1_row_in;
      rd_ok_ff   <= rd_ok_in;
      feature_ff <= feature_in;
      hid_ff     <= hid_in;
      score_ff   <= score_in;
      class_ff   <= class_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {score_ff, class_ff};

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DRAIN))
      else $error("result raised without the output row being scored");

   a_out_row_in_drain: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && (s1_row_ff == OUT_ROW)) |-> (state_ff == ST_DRAIN))
      else $error("output row scored outside drain");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (score_ff <= SCORE_W'(HIDDEN_COUNT)))
      else $error("score above row width");

   a_class_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (class_ff == (score_ff > threshold)))
      else $error("class bit disagrees with score and threshold");

   a_no_read_on_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("weight write while rows are being read");

endmodule

### rtl/bmlp_ram.sv
module bmlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bmlp_agree.sv
module bmlp_agree
   import bmlp_pkg::*;
(
   input  logic [ROW_BITS-1:0] operand,
   input  logic [ROW_BITS-1:0] weight,
   input  logic [THR_W-1:0]    threshold,
   output agree_result_type    result
);

   logic [POP_W-1:0] lv [POP_LEVELS+1];

   // xnor then a seven level lane-wise popcount tree
   always_comb begin
      lv[0] = {(POP_W-ROW_BITS)'(0), ~(operand ^ weight)};
      for (int l = 0; l < POP_LEVELS; l++) begin
         lv[l+1] = (lv[l] & POP_MASK[l]) + ((lv[l] >> (1 << l)) & POP_MASK[l]);
      end
   end

   assign result.count = lv[POP_LEVELS][SCORE_W-1:0];
   assign result.fire  = (lv[POP_LEVELS][SCORE_W-1:0] > threshold);

endmodule

### rtl/bmlp_csr.sv
module bmlp_csr
   import bmlp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output logic [THR_W-1:0]  threshold
);

   logic [THR_W-1:0] threshold_ff;
   logic [THR_W-1:0] threshold_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_FIRE_THRESHOLD);

   always_comb begin
      threshold_in = threshold_ff;
      if (wr_hit) begin
         threshold_in = pwdata[THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_FIRE_THRESHOLD) begin
         prdata = {(32-THR_W)'(0), threshold_ff};
      end
   end

   assign threshold = threshold_ff;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import bmlp_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int ITEM_GOAL   = 1700;
   localparam int PRINT_CAP   = 40;
   localparam logic [2:0]  THR_ADDR = 3'(4 * REG_FIRE_THRESHOLD);
   localparam logic [63:0] ALL64 = '1;
   localparam logic [55:0] ALL56 = '1;
   localparam logic [63:0] ALT64 = 64'haaaa_aaaa_aaaa_aaaa;
   localparam logic [55:0] ALT56 = 56'h55_5555_5555_5555;

   typedef struct packed {
      logic       cls;
      logic [6:0] score;
   } verdict_type;

   typedef enum { STEP_WORD, STEP_THRESHOLD } step_kind_type;

   typedef struct {
      step_kind_type kind;
      logic [6:0]    thr_value;
      op_type        op;
      logic [6:0]    row;
      logic [63:0]   wh;
      logic [55:0]   wl;
      logic [63:0]   fh;
      logic [55:0]   fl;
      bit            typed;
      verdict_type   typed_v;
   } plan_step_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [247:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   binarized_mlp_classifier_core dut (.*);

   // predictor state
   logic [63:0] wt_hi [ROW_COUNT];
   logic [55:0] wt_lo [ROW_COUNT];
   logic [6:0]  thr;

   verdict_type   pending_verdicts [$];
   plan_step_type directed_plan [$];

   bit calm = 1'b0;
   int errors = 0;
   int n_classify = 0;
   int n_write = 0;
   int n_ignored = 0;
   int n_thr = 0;
   int rsp_wait = 0;
   int rsp_stall;
   int quiet = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic int row_agreement(int r, logic [63:0] hi, logic [55:0] lo);
      logic [63:0] xh;
      logic [55:0] xl;
      xh = ~(hi ^ wt_hi[r]);
      xl = ~(lo ^ wt_lo[r]);
      return $countones(xh) + $countones(xl);
   endfunction

   function automatic verdict_type score_features(logic [63:0] fh, logic [55:0] fl);
      logic [63:0] hid_hi;
      logic [55:0] hid_lo;
      int agree;
      verdict_type v;
      hid_hi = '0;
      hid_lo = '0;
      // first neuron lands at the top of the low word
      for (int n = 0; n < HIDDEN_COUNT; n++) begin
         agree = row_agreement(n, fh, fl);
         if (n < LOW_BITS) hid_lo[LOW_BITS-1-n] = (agree > thr);
         else hid_hi[HIGH_BITS-1-(n-LOW_BITS)] = (agree > thr);
      end
      agree = row_agreement(HIDDEN_COUNT, hid_hi, hid_lo);
      v.score = 7'(agree);
      v.cls = (agree > thr);
      return v;
   endfunction

   function automatic void plan_thr(logic [6:0] value);
      plan_step_type s;
      s = '{kind: STEP_THRESHOLD, thr_value: value, op: OP_WRITE, row: '0, wh: '0,
            wl: '0, fh: '0, fl: '0, typed: 1'b0, typed_v: '0};
      directed_plan.push_back(s);
   endfunction

   function automatic void plan_word(op_type op, logic [6:0] row, logic [63:0] wh,
                                     logic [55:0] wl, logic [63:0] fh, logic [55:0] fl,
                                     bit typed = 1'b0, logic cls = 1'b0,
                                     logic [6:0] score = '0);
      plan_step_type s;
      s = '{kind: STEP_WORD, thr_value: '0, op: op, row: row, wh: wh, wl: wl,
            fh: fh, fl: fl, typed: typed, typed_v: '{cls, score}};
      directed_plan.push_back(s);
   endfunction

   // one word on the request channel; ignored fields carry random data
   task automatic send_word(op_type op, logic [6:0] row, logic [63:0] wh, logic [55:0] wl,
                            logic [63:0] fh, logic [55:0] fl, bit typed = 1'b0,
                            verdict_type typed_v = '0);
      int gap;
      logic [6:0]  row_d;
      logic [63:0] wh_d, fh_d;
      logic [55:0] wl_d, fl_d;
      gap = draw_gap();
      row_d = row; wh_d = wh; wl_d = wl; fh_d = fh; fl_d = fl;
      if (op == OP_WRITE) begin
         fh_d = rand64();
         fl_d = 56'(rand64());
      end else begin
         row_d = 7'($urandom());
         wh_d = rand64();
         wl_d = 56'(rand64());
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, fl_d, fh_d, wl_d, wh_d, row_d};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_WRITE) begin
         if (row < ROW_COUNT) begin
            wt_hi[row] = wh;
            wt_lo[row] = wl;
            n_write++;
         end else begin
            n_ignored++;
         end
      end else begin
         pending_verdicts.push_back(typed ? typed_v : score_features(fh, fl));
         n_classify++;
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      // a trailing weight write may still be in flight
      repeat (4) @(posedge clock);
   endtask

   task automatic set_threshold(logic [6:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= THR_ADDR;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      thr = value;
      n_thr++;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== 32'(value)) begin
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t threshold readback: expected %0d actual %0d",
                     $time, value, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_features(output logic [63:0] fh, output logic [55:0] fl);
      int r;
      case ($urandom_range(0, 9))
         0: begin fh = '0; fl = '0; end
         1: begin fh = ALL64; fl = ALL56; end
         2, 3: begin fh = rand64(); fl = 56'(rand64()); end
         default: begin
            // near one stored row, which then sits close to full agreement
            r = $urandom_range(0, HIDDEN_COUNT);
            fh = wt_hi[r] ^ (rand64() & rand64() & rand64());
            fl = wt_lo[r] ^ 56'(rand64() & rand64() & ($urandom_range(0, 1) ? '1 : rand64()));
         end
      endcase
   endtask

   task automatic random_write();
      logic [6:0]  row;
      logic [63:0] wh;
      logic [55:0] wl;
      case ($urandom_range(0, 11))
         0: row = 7'($urandom_range(ROW_COUNT, 127));
         1, 2, 3: row = OUT_ROW;
         default: row = 7'($urandom_range(0, HIDDEN_COUNT - 1));
      endcase
      case ($urandom_range(0, 9))
         0: begin wh = '0; wl = '0; end
         1: begin wh = ALL64; wl = ALL56; end
         default: begin wh = rand64(); wl = 56'(rand64()); end
      endcase
      send_word(OP_WRITE, row, wh, wl, '0, '0);
   endtask

   // result channel: random back-pressure and checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_tready && rsp_tvalid) begin
         if (pending_verdicts.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t unexpected result word: expected none actual %h",
                        $time, rsp_tdata);
         end else begin
            if (rsp_tdata[0] !== pending_verdicts[0].cls) begin
               errors++;
               if (errors <= PRINT_CAP)
                  $display("%0t class_bit: expected %0d actual %0d",
                           $time, pending_verdicts[0].cls, rsp_tdata[0]);
            end
            if (rsp_tdata[7:1] !== pending_verdicts[0].score) begin
               errors++;
               if (errors <= PRINT_CAP)
                  $display("%0t output_score: expected %0d actual %0d",
                           $time, pending_verdicts[0].score, rsp_tdata[7:1]);
            end
            void'(pending_verdicts.pop_front());
         end
         rsp_stall = draw_gap();
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait <= rsp_stall - 1;
         end
      end else if (!rsp_tready) begin
         if (rsp_wait == 0) rsp_tready <= 1'b1;
         else rsp_wait <= rsp_wait - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_psel && csr_penable)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("%0t watchdog: no traffic for %0d cycles", $time, QUIET_LIMIT);
         $display("binarized_mlp_classifier_core verification failed");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      logic [63:0] fh;
      logic [55:0] fl;
      int n_words;
      int n_scores;
      int pick;
      logic [6:0] value;

      foreach (wt_hi[r]) begin
         wt_hi[r] = '0;
         wt_lo[r] = '0;
      end
      thr = THR_RESET;

      // zero weights: features decide whether every neuron fires or none does
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 1'b0, 7'd0);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALL64, ALL56, 1'b1, 1'b1, 7'd120);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALL64, '0, 1'b1, 1'b1, 7'd120);
      // threshold above the top count: nothing can fire
      plan_thr(7'd127);
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 1'b0, 7'd120);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALT64, ALT56, 1'b1, 1'b0, 7'd120);
      plan_thr(7'd120);
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 1'b0, 7'd120);
      plan_thr(7'd0);
      plan_word(OP_WRITE, OUT_ROW, ALL64, ALL56, '0, '0);
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 1'b1, 7'd120);
      // rows past the output row must be dropped
      plan_word(OP_WRITE, 7'd121, '0, '0, '0, '0);
      plan_word(OP_WRITE, 7'd127, '0, '0, '0, '0);
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0, 1'b1, 1'b1, 7'd120);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALL64, ALL56, 1'b1, 1'b0, 7'd0);
      plan_thr(THR_RESET);
      plan_word(OP_WRITE, 7'd0, ALL64, ALL56, '0, '0);
      plan_word(OP_WRITE, 7'd55, '0, ALL56, '0, '0);
      plan_word(OP_WRITE, 7'd56, ALL64, '0, '0, '0);
      plan_word(OP_WRITE, 7'd119, ALT64, ALT56, '0, '0);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALT64, ALT56);
      plan_word(OP_CLASSIFY, '0, '0, '0, ALL64, ALL56);
      plan_word(OP_WRITE, OUT_ROW, 64'hf0f0_f0f0_f0f0_f0f0, 56'h0f_0f0f_0f0f_0f0f, '0, '0);
      plan_word(OP_CLASSIFY, '0, '0, '0, '0, '0);
      plan_word(OP_CLASSIFY, '0, '0, '0, ~ALT64, ALT56);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_THRESHOLD)
            set_threshold(directed_plan[i].thr_value);
         else
            send_word(directed_plan[i].op, directed_plan[i].row, directed_plan[i].wh,
                      directed_plan[i].wl, directed_plan[i].fh, directed_plan[i].fl,
                      directed_plan[i].typed, directed_plan[i].typed_v);
      end

      // random part: set a threshold, load a batch of rows, then score features amid writes
      while (n_classify + n_write < ITEM_GOAL) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: value = 7'd0;
            1: value = 7'd120;
            2: value = 7'd127;
            3: value = THR_RESET;
            4: value = 7'($urandom_range(0, 127));
            default: value = 7'($urandom_range(50, 70));
         endcase
         set_threshold(value);
         calm = ($urandom_range(0, 4) == 0);
         n_words = $urandom_range(0, 20);
         n_scores = $urandom_range(1, 10);
         repeat (n_words) random_write();
         repeat (n_scores) begin
            if ($urandom_range(0, 5) == 0) random_write();
            random_features(fh, fl);
            send_word(OP_CLASSIFY, '0, '0, '0, fh, fl);
         end
      end

      settle();
      repeat (130) @(posedge clock);
      $display("covered %0d classifications and %0d weight row writes (%0d dropped rows)",
               n_classify, n_write, n_ignored);
      $display("under %0d threshold settings, with random gaps and back-pressure", n_thr);
      if (errors == 0) begin
         $display("binarized_mlp_classifier_core verification clean");
      end else begin
         $display("binarized_mlp_classifier_core verification failed");
      end
      $finish;
   end

endmodule
